@@ rtl/hrlp_pkg.sv @@
// Package for the HTTP request line parser: widths, status codes, version phases,
// register indexes and the channel payload types. No dependencies.
package hrlp_pkg;

   localparam int MaxLine  = 8192;
   localparam int PosW     = 13;
   localparam int TrkW     = 15;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 1;

   localparam logic [CsrIdxW-1:0] CSR_RELAXED = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_LAX     = 1'd1;

   typedef enum logic [2:0] {
      ST_MORE    = 3'd0,
      ST_OK      = 3'd1,
      ST_BAD     = 3'd2,
      ST_VERSION = 3'd3,
      ST_LONG    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      PH_H = 4'd0, PH_T1 = 4'd1, PH_T2 = 4'd2, PH_P = 4'd3, PH_SL = 4'd4,
      PH_MAJ0 = 4'd5, PH_MAJ = 4'd6, PH_MIN0 = 4'd7, PH_MIN = 4'd8,
      PH_BAD_PREFIX = 4'd9, PH_BAD_NUMBER = 4'd10
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_flag;
   } req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [PosW-1:0] method_start;
      logic [PosW-1:0] method_end;
      logic [PosW-1:0] uri_start;
      logic [PosW-1:0] uri_end;
      logic [PosW-1:0] version_start;
      logic [PosW-1:0] line_last;
      logic [PosW-1:0] terminator_pos;
      logic [15:0]     version_major;
      logic [15:0]     version_minor;
   } rsp_type;

   // Snapshot of the tracker handed from the front to the back stage.
   typedef struct packed {
      logic            done;      // held result is to be repeated
      logic            finish;    // line complete, evaluate
      logic [2:0]      status;    // status when not finishing
      logic            lax;
      logic [TrkW-1:0] s;
      logic [TrkW-1:0] fw;
      logic [TrkW-1:0] lw;
      logic [TrkW-1:0] sw;
      logic [TrkW-1:0] uec;
      logic [TrkW-1:0] lend;
      logic [TrkW-1:0] term;
      logic [3:0]      phase;
      logic [16:0]     major;
      logic [16:0]     minor;
   } job_type;

endpackage

@@ rtl/hrlp_stream_if.sv @@
// Valid/ready channel interface carrying one payload word.
// Payload type is supplied by the instantiating module.
interface hrlp_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/http_request_line_parser_unit.sv @@
// Top level of the HTTP request line parser: front tracker, job queue, back evaluator.
// Depends on hrlp_pkg, hrlp_stream_if, hrlp_front, hrlp_queue and hrlp_back.
//
//   channel | direction | payload
//   req     | in        | data_byte, start_flag
//   rsp     | out       | status and nine offset/version fields
//   csr     | in        | relaxed_mode (index 0), lax_version (index 1)
//
// One byte is accepted per cycle unless the result output stalls; its result is registered
// in the queue and then in the back stage. The rate is set by the front stage tracker update.
// Reset is synchronous and clears all line state and both registers.
// A stalled result output backs up through the two-entry queue to req.ready.
module http_request_line_parser_unit (
   input  logic                         clock,
   input  logic                         reset,
   hrlp_stream_if.sink                  req,
   hrlp_stream_if.source                rsp,
   input  logic                         csr_write_enable,
   input  logic [hrlp_pkg::CsrIdxW-1:0] csr_index,
   input  logic [hrlp_pkg::CsrDataW-1:0] csr_write_data
);
   import hrlp_pkg::*;

   logic    relaxed_ff, lax_ff;
   logic    fq_valid, fq_ready, qb_valid, qb_ready;
   job_type fq_job, qb_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         relaxed_ff <= 1'b0;
         lax_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RELAXED: relaxed_ff <= csr_write_data[0];
            CSR_LAX:     lax_ff     <= csr_write_data[0];
            default:     ;
         endcase
      end
   end

   hrlp_front u_front (
      .clock, .reset, .relaxed(relaxed_ff), .lax(lax_ff),
      .in_valid(req.valid), .in_data(req.payload), .in_ready(req.ready),
      .job_valid(fq_valid), .job(fq_job), .job_ready(fq_ready)
   );

   hrlp_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_job(fq_job), .in_ready(fq_ready),
      .out_valid(qb_valid), .out_job(qb_job), .out_ready(qb_ready)
   );

   hrlp_back u_back (
      .clock, .reset, .job_valid(qb_valid), .job(qb_job), .job_ready(qb_ready),
      .out_valid(rsp.valid), .out_data(rsp.payload), .out_ready(rsp.ready)
   );
endmodule

@@ rtl/hrlp_front.sv @@
// Front stage: tracks positions and the version sub-machine byte by byte.
// Depends on hrlp_pkg; emits one job per byte to the queue.
module hrlp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               relaxed,
   input  logic               lax,
   input  logic               in_valid,
   input  hrlp_pkg::req_type  in_data,
   output logic               in_ready,
   output logic               job_valid,
   output hrlp_pkg::job_type  job,
   input  logic               job_ready
);
   import hrlp_pkg::*;

   logic [TrkW-1:0] pos_ff, pos_in, mb_ff, mb_in, fw_ff, fw_in, lw_ff, lw_in;
   logic [TrkW-1:0] sw_ff, sw_in, ln_ff, ln_in, uec_ff, uec_in, ll_ff, ll_in;
   logic            cr_ff, cr_in, fin_ff, fin_in;
   logic [3:0]      ph_ff, ph_in;
   logic [16:0]     maj_ff, maj_in, min_ff, min_in;
   logic            fire;
   logic [7:0]      b, lc;
   logic [16:0]     acc;
   logic [7:0]      hw;
   logic            dig, ws;
   logic [2:0]      st;
   logic            fin;
   logic [TrkW-1:0] lend;
   logic [TrkW-1:0] p;
   logic            s_fin;
   logic [TrkW-1:0] s_mb, s_fw, s_lw, s_sw, s_ln, s_uec, s_ll;
   logic            s_cr;
   logic [3:0]      s_ph;
   logic [16:0]     s_maj, s_min;

   assign in_ready  = job_ready;
   assign job_valid = in_valid;
   assign fire      = in_valid && job_ready;
   assign b         = in_data.data_byte;
   assign lc        = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
   assign dig       = b >= 8'h30 && b <= 8'h39;
   assign ws        = b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B ||
                      b == 8'h0C || b == 8'h0D;

   // The expected prefix letter follows the phase as seen after a start of line.
   always_comb begin
      unique case (s_ph[2:0])
         3'd0:    hw = 8'h68;
         3'd1:    hw = 8'h74;
         3'd2:    hw = 8'h74;
         3'd3:    hw = 8'h70;
         default: hw = 8'h2F;
      endcase
   end

   always_comb begin
      // Start of line clears the tracker before the byte is applied.
      if (in_data.start_flag) begin
         p = '0; s_mb = '0; s_fw = '1; s_lw = '1; s_sw = '1; s_ln = '1;
         s_uec = '1; s_ll = '1; s_cr = 1'b0; s_ph = '0; s_maj = '0; s_min = '0;
         s_fin = 1'b0;
      end else begin
         p = pos_ff; s_mb = mb_ff; s_fw = fw_ff; s_lw = lw_ff; s_sw = sw_ff;
         s_ln = ln_ff; s_uec = uec_ff; s_ll = ll_ff; s_cr = cr_ff; s_ph = ph_ff;
         s_maj = maj_ff; s_min = min_ff; s_fin = fin_ff;
      end
      pos_in = p; mb_in = s_mb; fw_in = s_fw; lw_in = s_lw; sw_in = s_sw;
      ln_in = s_ln; uec_in = s_uec; ll_in = s_ll; cr_in = s_cr; ph_in = s_ph;
      maj_in = s_maj; min_in = s_min; fin_in = s_fin;
      st = ST_MORE; fin = 1'b0; lend = s_ll; acc = '0;
      if (!s_fin) begin
         if (s_cr) begin
            if (b == 8'h0A) fin = 1'b1;
            else if (!(b == 8'h0D && relaxed)) st = ST_BAD;
         end else begin
            if (relaxed && b == 8'h20 && s_mb == p) mb_in = p + 1'b1;
            if (b == 8'h20) begin
               lw_in = p;
               if ($signed(s_fw) < $signed(mb_in)) fw_in = p;
               uec_in = s_ln; ph_in = '0; maj_in = '0; min_in = '0;
            end
            if ($signed(s_sw) < $signed(fw_in) && b != 8'h20 && b != 8'h09) sw_in = p;
            if (b == 8'h0A) begin
               fin = 1'b1; lend = p - 1'b1;
            end else if (b == 8'h0D) begin
               cr_in = 1'b1; ll_in = p - 1'b1;
            end else begin
               if (!ws) ln_in = p;
               if (b != 8'h20) begin
                  if (ph_in < 4'd5) begin
                     ph_in = (lc == hw) ? ph_in + 1'b1 : PH_BAD_PREFIX;
                  end else if (ph_in == PH_MAJ0 || ph_in == PH_MAJ) begin
                     if (dig) begin
                        acc = (ph_in == PH_MAJ0) ? 17'd0 : maj_in;
                        maj_in = ({acc[13:0], 3'b0} + {acc[15:0], 1'b0}) + {9'd0, b - 8'h30};
                        ph_in = (acc >= 17'd6554 || maj_in[16]) ? PH_BAD_NUMBER : PH_MAJ;
                     end else if (ph_in == PH_MAJ && b == 8'h2E) ph_in = PH_MIN0;
                     else ph_in = PH_BAD_NUMBER;
                  end else if (ph_in == PH_MIN0 || ph_in == PH_MIN) begin
                     if (dig) begin
                        acc = (ph_in == PH_MIN0) ? 17'd0 : min_in;
                        min_in = ({acc[13:0], 3'b0} + {acc[15:0], 1'b0}) + {9'd0, b - 8'h30};
                        ph_in = (acc >= 17'd6554 || min_in[16]) ? PH_BAD_NUMBER : PH_MIN;
                     end else ph_in = PH_BAD_NUMBER;
                  end
               end
            end
         end
         pos_in = p + 1'b1;
         if (!fin && st == ST_MORE && pos_in >= TrkW'(MaxLine)) st = ST_LONG;
         if (fin || st != ST_MORE) fin_in = 1'b1;
      end
      if (fin) ll_in = lend;
      job.done = s_fin; job.finish = fin; job.status = st; job.lax = lax;
      job.s = mb_in; job.fw = fw_in; job.lw = lw_in; job.sw = sw_in;
      job.uec = uec_in; job.lend = lend; job.term = p; job.phase = ph_in;
      job.major = maj_in; job.minor = min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; mb_ff <= '0; fw_ff <= '1; lw_ff <= '1; sw_ff <= '1;
         ln_ff <= '1; uec_ff <= '1; ll_ff <= '1; cr_ff <= 1'b0; ph_ff <= '0;
         maj_ff <= '0; min_ff <= '0; fin_ff <= 1'b0;
      end else if (fire) begin
         pos_ff <= pos_in; mb_ff <= mb_in; fw_ff <= fw_in; lw_ff <= lw_in;
         sw_ff <= sw_in; ln_ff <= ln_in; uec_ff <= uec_in; ll_ff <= ll_in;
         cr_ff <= cr_in; ph_ff <= ph_in; maj_ff <= maj_in; min_ff <= min_in;
         fin_ff <= fin_in;
      end
   end
endmodule

@@ rtl/hrlp_queue.sv @@
// Two-entry queue of jobs between the front and back stages.
// Depends on hrlp_pkg.
module hrlp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  hrlp_pkg::job_type in_job,
   output logic              in_ready,
   output logic              out_valid,
   output hrlp_pkg::job_type out_job,
   input  logic              out_ready
);
   import hrlp_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job   = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign wp_in     = wp_ff ^ push;
   assign rp_in     = rp_ff ^ pop;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule

@@ rtl/hrlp_back.sv @@
// Back stage: evaluates a finished line, holds the final result and drives
// the registered result word. Depends on hrlp_pkg.
module hrlp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  hrlp_pkg::job_type job,
   output logic              job_ready,
   output logic              out_valid,
   output hrlp_pkg::rsp_type out_data,
   input  logic              out_ready
);
   import hrlp_pkg::*;

   rsp_type         res, held_ff, held_in, out_ff;
   logic            ov_ff;
   logic [2:0]      st;
   logic [TrkW-1:0] uend, vst;
   logic [16:0]     vmaj, vmin;
   logic            take;

   assign job_ready = !ov_ff || out_ready;
   assign take      = job_valid && job_ready;
   assign out_valid = ov_ff;
   assign out_data  = out_ff;

   function automatic logic lt(input logic [TrkW-1:0] a, input logic [TrkW-1:0] c);
      return $signed(a) < $signed(c);
   endfunction

   always_comb begin
      st = job.status; uend = job.lend; vst = '0; vmaj = '0; vmin = 17'd9;
      if (job.finish) begin
         st = ST_OK;
         if (lt(job.lend, job.s) || lt(job.lend, job.fw) || lt(job.fw, job.s) ||
             lt(job.fw - 1'b1, job.s)) st = ST_BAD;
         else if (lt(job.lend, job.sw) || lt(job.sw, job.s)) st = ST_BAD;
         else if (!(lt(job.lw, job.sw) && !lt(job.lw, job.s))) begin
            uend = job.uec;
            if (lt(job.lw, job.sw) || lt(job.uec, job.sw)) st = ST_BAD;
            else if (!lt(job.lw, job.lend)) st = ST_BAD;
            else if (job.phase < 4'd5 || job.phase == PH_BAD_PREFIX) begin
               if (!job.lax) st = ST_VERSION;
               else uend = job.lend;
            end else if (job.phase != PH_MIN) st = ST_VERSION;
            else begin
               vst = job.lw + 1'b1; vmaj = job.major; vmin = job.minor;
            end
         end
      end
      res = '0;
      res.status = st;
      if (st == ST_OK) begin
         res.method_start   = job.s[PosW-1:0];
         res.method_end     = job.fw[PosW-1:0] - 1'b1;
         res.uri_start      = job.sw[PosW-1:0];
         res.uri_end        = uend[PosW-1:0];
         res.version_start  = vst[PosW-1:0];
         res.line_last      = job.lend[PosW-1:0];
         res.terminator_pos = job.term[PosW-1:0];
         res.version_major  = vmaj[15:0];
         res.version_minor  = vmin[15:0];
      end
      if (job.done) res = held_ff;
      held_in = (st != ST_MORE && !job.done) ? res : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (job_ready) begin
         ov_ff <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff  <= res;
         held_ff <= held_in;
      end
   end
endmodule

@@ rtl/hrlp_checker.sv @@
// Port-level checks for the HTTP request line parser, bound to the top level.
// Depends on hrlp_pkg.
module hrlp_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hrlp_pkg::rsp_type rsp_payload
);
   import hrlp_pkg::*;

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= 3'd4) else $error("status out of range");

   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.version_minor == 16'd0 &&
      rsp_payload.terminator_pos == '0) else $error("fields set without ok");

   a_ok_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_OK |->
      rsp_payload.line_last < rsp_payload.terminator_pos) else $error("terminator order");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload)) else $error("unstable");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("valid after reset");
endmodule

bind http_request_line_parser_unit hrlp_port_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);

@@ bench/hrlp_checker.sv @@
// Result checker for the HTTP request line parser: watches both channels and the
// register port, predicts each result word and compares it. Depends on hrlp_pkg.
module hrlp_checker
   import hrlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   hrlp_stream_if              req,
   hrlp_stream_if              rsp,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   output int                  fail_count,
   output int                  pending,
   output int                  ok_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic    relaxed, lax;
   int      pos, mbegin, fsp, lsp, uri_pos, last_ns, uend_cand, cr_pend, line_last;
   int      vphase, vmajor, vminor, final_st;
   rsp_type held;
   rsp_type expected_words[$];

   function automatic void clear_line();
      pos = 0; mbegin = 0; fsp = -1; lsp = -1; uri_pos = -1; last_ns = -1;
      uend_cand = -1; cr_pend = 0; line_last = -1; vphase = PH_H;
      vmajor = 0; vminor = 0; final_st = ST_MORE; held = '0;
   endfunction

   function automatic void version_step(logic [7:0] b);
      logic [7:0] lc;
      logic [7:0] proto [5];
      logic       dig;
      proto = '{"h", "t", "t", "p", "/"};
      lc  = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      dig = b >= "0" && b <= "9";
      if (vphase < PH_MAJ0) begin
         vphase = (lc == proto[vphase]) ? vphase + 1 : PH_BAD_PREFIX;
      end else if (vphase == PH_MAJ0 || vphase == PH_MAJ) begin
         if (dig) begin
            if (vphase == PH_MAJ0) vmajor = 0;
            vmajor = vmajor * 10 + int'(b - "0");
            vphase = (vmajor >= 65536) ? PH_BAD_NUMBER : PH_MAJ;
         end else if (vphase == PH_MAJ && b == ".") begin
            vphase = PH_MIN0;
         end else begin
            vphase = PH_BAD_NUMBER;
         end
      end else if (vphase == PH_MIN0 || vphase == PH_MIN) begin
         if (dig) begin
            if (vphase == PH_MIN0) vminor = 0;
            vminor = vminor * 10 + int'(b - "0");
            vphase = (vminor >= 65536) ? PH_BAD_NUMBER : PH_MIN;
         end else begin
            vphase = PH_BAD_NUMBER;
         end
      end
   endfunction

   // Judges a complete line; lend is the last content byte.
   function automatic int judge_line(input int lend, input int term, output rsp_type r);
      int uend, vstart, vmaj, vmin;
      r = '0; vstart = 0; vmaj = 0; vmin = 9;
      line_last = lend;
      if (mbegin > lend || fsp > lend || fsp < mbegin || fsp - 1 < mbegin) return ST_BAD;
      if (uri_pos > lend || uri_pos < mbegin) return ST_BAD;
      if (lsp < uri_pos && lsp >= mbegin) begin
         uend = lend;
      end else begin
         if (lsp < uri_pos || uend_cand < uri_pos) return ST_BAD;
         uend = uend_cand;
         if (lsp >= lend) return ST_BAD;
         if (vphase < PH_MAJ0 || vphase == PH_BAD_PREFIX) begin
            if (!lax) return ST_VERSION;
            uend = lend;
         end else if (vphase != PH_MIN) begin
            return ST_VERSION;
         end else begin
            vstart = lsp + 1; vmaj = vmajor; vmin = vminor;
         end
      end
      r.method_start   = mbegin[PosW-1:0];
      r.method_end     = PosW'(fsp - 1);
      r.uri_start      = uri_pos[PosW-1:0];
      r.uri_end        = uend[PosW-1:0];
      r.version_start  = vstart[PosW-1:0];
      r.line_last      = lend[PosW-1:0];
      r.terminator_pos = term[PosW-1:0];
      r.version_major  = vmaj[15:0];
      r.version_minor  = vmin[15:0];
      return ST_OK;
   endfunction

   function automatic rsp_type predict_word(logic [7:0] b, logic sf);
      rsp_type r;
      int      p, st;
      r = '0; st = ST_MORE;
      if (sf) clear_line();
      if (final_st != ST_MORE) return held;
      p = pos;
      if (cr_pend != 0) begin
         if (b == 8'h0A) st = judge_line(line_last, p, r);
         else if (!(b == 8'h0D && relaxed)) st = ST_BAD;
      end else begin
         if (relaxed && b == " " && mbegin == p) mbegin = p + 1;
         if (b == " ") begin
            lsp = p;
            if (fsp < mbegin) fsp = p;
            uend_cand = last_ns;
            vphase = PH_H; vmajor = 0; vminor = 0;
         end
         if (uri_pos < fsp && b != " " && b != 8'h09) uri_pos = p;
         if (b == 8'h0A) begin
            st = judge_line(p - 1, p, r);
         end else if (b == 8'h0D) begin
            cr_pend = 1;
            line_last = p - 1;
         end else begin
            if (!(b == " " || (b >= 8'h09 && b <= 8'h0D))) last_ns = p;
            if (b != " ") version_step(b);
         end
      end
      pos = p + 1;
      if (st == ST_MORE && pos >= MaxLine) st = ST_LONG;
      if (st != ST_OK) r = '0;
      r.status = st[2:0];
      if (st != ST_MORE) begin
         final_st = st;
         held = r;
      end
      return r;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type w, got;
      if (reset) begin
         relaxed = 1'b0; lax = 1'b0;
         clear_line();
         expected_words.delete();
         fail_count <= 0; ok_count <= 0; pending <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (expected_words.size() == 0) begin
               $display("%0t: result word with nothing expected, actual status %0d",
                        $realtime, got.status);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               compare_field("status", w.status, got.status);
               compare_field("method_start", w.method_start, got.method_start);
               compare_field("method_end", w.method_end, got.method_end);
               compare_field("uri_start", w.uri_start, got.uri_start);
               compare_field("uri_end", w.uri_end, got.uri_end);
               compare_field("version_start", w.version_start, got.version_start);
               compare_field("line_last", w.line_last, got.line_last);
               compare_field("terminator_pos", w.terminator_pos, got.terminator_pos);
               compare_field("version_major", w.version_major, got.version_major);
               compare_field("version_minor", w.version_minor, got.version_minor);
               if (w.status == ST_OK) ok_count <= ok_count + 1;
            end
         end
         if (req.valid && req.ready)
            expected_words.push_back(predict_word(req.payload.data_byte,
                                                  req.payload.start_flag));
         // Register changes act from the next word on.
         if (csr_write_enable) begin
            if (csr_index == CSR_RELAXED) relaxed = csr_write_data[0];
            else if (csr_index == CSR_LAX) lax = csr_write_data[0];
         end
         pending <= expected_words.size();
      end
   end

endmodule

@@ bench/tb_top.sv @@
// Top of the parser testbench: clock, reset, request stimulus, result stalls and
// the verdict. Depends on hrlp_pkg, hrlp_stream_if, hrlp_checker and the block.
module tb_top;
   import hrlp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Limit = 1_000_000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_RELAXED;
   logic [CsrDataW-1:0] csr_write_data = '0;
   int                  fail_count, pending, ok_count;
   int                  cycles = 0;
   int                  words_sent = 0;
   int                  lines_sent = 0;
   bit                  no_gaps = 1'b0;
   bit                  cur_relaxed = 1'b0;
   int                  stall_left = 0;

   hrlp_stream_if #(.payload_type(req_type)) req_ch (clock);
   hrlp_stream_if #(.payload_type(rsp_type)) rsp_ch (clock);

   http_request_line_parser_unit DUT (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   hrlp_checker u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count), .pending(pending),
      .ok_count(ok_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > Limit) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   // Result side stalls at random, except during stretches without gaps.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_left = gap_length();
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   task automatic send_word(logic [7:0] b, logic sf);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= '{data_byte: b, start_flag: sf};
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_line(byte unsigned q[$]);
      foreach (q[i]) send_word(q[i], i == 0);
      lines_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic set_modes(bit relaxed_on, bit lax_on);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_RELAXED;
      csr_write_data   <= relaxed_on;
      @(negedge clock);
      csr_index        <= CSR_LAX;
      csr_write_data   <= lax_on;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_relaxed = relaxed_on;
   endtask

   function automatic void add_text(ref byte unsigned q[$], input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic void add_number(ref byte unsigned q[$]);
      int r, v;
      r = $urandom_range(19);
      if (r == 0) v = 65535;
      else if (r == 1) v = 65536;
      else if (r == 2) v = $urandom_range(99999);
      else v = $urandom_range(r < 6 ? 99 : 9);
      add_text(q, $sformatf("%0d", v));
   endfunction

   // Builds a mostly well-formed request line with random content.
   function automatic void build_line(ref byte unsigned q[$]);
      int    form, n;
      string upper_word, lower_word;
      upper_word = "HTTP/";
      lower_word = "http/";
      q.delete();
      if (cur_relaxed && $urandom_range(2) == 0) repeat ($urandom_range(1, 3)) q.push_back(" ");
      repeat ($urandom_range(1, 7)) q.push_back(byte'($urandom_range("A", "Z")));
      q.push_back(" ");
      if ($urandom_range(7) == 0) q.push_back($urandom_range(1) ? " " : 8'h09);
      q.push_back("/");
      repeat ($urandom_range(0, 10)) q.push_back(byte'($urandom_range(8'h21, 8'h7E)));
      form = $urandom_range(99);
      if (form >= 15) begin
         q.push_back(" ");
         if ($urandom_range(9) == 0) q.push_back(" ");
         if (form < 30) begin
            add_text(q, $urandom_range(1) ? "FTP/1.0" : "HTXP/2");
         end else begin
            for (int i = 0; i < upper_word.len(); i++)
               q.push_back($urandom_range(1) ? upper_word[i] : lower_word[i]);
            add_number(q);
            if ($urandom_range(15) != 0) q.push_back(".");
            add_number(q);
            if ($urandom_range(15) == 0) q.push_back("x");
         end
      end
      n = $urandom_range(99);
      if (n < 35) q.push_back(8'h0A);
      else if (n < 80) add_text(q, "\r\n");
      else if (n < 92) add_text(q, "\r\r\n");
      else add_text(q, "\rx");
      // A few lines are broken by one random byte.
      if ($urandom_range(9) == 0) q[$urandom_range(q.size() - 1)] = byte'($urandom_range(255));
      if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) q.push_back(byte'($urandom));
   endfunction

   task automatic random_phase(int words);
      byte unsigned q[$];
      int start_count;
      start_count = words_sent;
      while (words_sent - start_count < words) begin
         no_gaps = ($urandom_range(5) == 0);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) send_word(byte'($urandom), $urandom_range(3) == 0);
         end else begin
            build_line(q);
            send_line(q);
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      byte unsigned q[$];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines: plain request, HTTP/0.9, bare CR, extreme version numbers.
      q.delete(); add_text(q, "GET / HTTP/1.1\r\n"); send_line(q);
      q.delete(); add_text(q, "A /\n"); send_line(q);
      send_word(8'hFF, 1'b0);
      q.delete(); add_text(q, "P /\rx"); send_line(q);
      q.delete(); add_text(q, "M / hTtP/65535.65535\n"); q.push_back(8'h00); send_line(q);
      q.delete(); add_text(q, "M / HTTP/1.65536\n"); send_line(q);
      q.delete(); add_text(q, "M / HTTP/1.1z\n"); send_line(q);
      set_modes(1'b1, 1'b1);
      q.delete(); add_text(q, "  G / XY\r\r\n"); send_line(q);

      // The sender holds off until every expected word has come back.
      wait_idle();
      random_phase(150);
      set_modes(1'b0, 1'b0);
      random_phase(150);
      set_modes(1'b1, 1'b0);
      random_phase(150);
      set_modes(1'b0, 1'b1);
      random_phase(150);

      wait_idle();
      repeat (10) @(negedge clock);
      $display("Sent %0d words in %0d lines over four register settings;", words_sent,
               lines_sent);
      $display("%0d lines parsed ok, the rest rejected or incomplete.", ok_count);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
